// ===== rtl/srr_pkg.sv =====
// Shared types and constants for the selective-repeat receiver.
// Holds the packet and result structs and the controller/datapath interface.
// Depends on nothing.
package srr_pkg;

    localparam int SEQ_FIELD_W      = 3;
    localparam int PAYLOAD_FIELD_W  = 64;

    localparam int WINDOW_DEF       = 4;
    localparam int SEQ_SPACE_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_FIELD_W-1:0]     seq_num;
        logic [PAYLOAD_FIELD_W-1:0] payload_word;
        logic                       checksum_ok;
    } pkt_item_t;

    typedef struct packed {
        logic                       result_kind;
        logic [SEQ_FIELD_W-1:0]     ack_num;
        logic [PAYLOAD_FIELD_W-1:0] delivered_payload;
        logic                       last;
    } res_item_t;

    typedef struct packed {
        logic accept;
        logic emit_ack;
        logic emit_deliver;
    } srr_cmd_t;

    typedef struct packed {
        logic good_pkt;
        logic start_deliver;
        logic more_deliver;
        logic out_free;
    } srr_status_t;

endpackage

// ===== rtl/selective_repeat_receiver_core.sv =====
// Selective-repeat ARQ receiver: acknowledges good packets, buffers them in
// the window and delivers in-order runs. From the ACK state after acceptance
// the acknowledgement goes to the result register, then a run of R (0 to
// WINDOW) deliveries, one result per cycle while the output is not stalled;
// a corrupt packet is dropped with no result. Reset clears the window base,
// the slot-full flags and all control state; no clearing pass.
module selective_repeat_receiver_core
    import srr_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_stall,
    input  pkt_item_t pkt,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    srr_cmd_t    cmd;
    srr_status_t status;

    srr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .status    (status),
        .cmd       (cmd)
    );

    srr_datapath #(
        .WINDOW       (WINDOW),
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/srr_datapath.sv =====
// Datapath of the selective-repeat receiver: window base, slot buffer and
// result register. Driven by srr_ctrl through srr_cmd_t; depends on srr_pkg.
module srr_datapath
    import srr_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pkt_item_t   pkt,
    input  srr_cmd_t    cmd,
    output srr_status_t status,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res
);

    localparam int SEQ_W = $clog2(SEQ_SPACE);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int OFF_W = ((SEQ_W > IDX_W) ? SEQ_W : IDX_W) + 2;
    localparam logic [OFF_W-1:0] SPACE_C  = OFF_W'(SEQ_SPACE);
    localparam logic [OFF_W-1:0] WINDOW_C = OFF_W'(WINDOW);
    localparam logic [SEQ_W-1:0] BASE_MAX = SEQ_W'(SEQ_SPACE - 1);

    logic [SEQ_W-1:0]        base_reg, base_next;
    logic [WINDOW-1:0]       full_reg, full_next;
    logic [PAYLOAD_BITS-1:0] payload_reg [WINDOW];
    logic [SEQ_FIELD_W-1:0]  seq_reg;
    logic                    zero_reg;
    logic                    res_valid_reg, res_valid_next;
    res_item_t               res_reg, res_next;

    logic [OFF_W-1:0] seq_red;
    logic [OFF_W-1:0] off_sum;
    logic [OFF_W-1:0] offset;
    logic             in_window;
    logic             do_write;
    logic [IDX_W-1:0] wr_idx;

    always_comb
    begin
        seq_red = OFF_W'(pkt.seq_num);
        for (int k = 0; k < 8; k++)
        begin
            if (seq_red >= SPACE_C)
            begin
                seq_red = seq_red - SPACE_C;
            end
        end
        off_sum = seq_red + SPACE_C - OFF_W'(base_reg);
        offset  = (off_sum >= SPACE_C) ? (off_sum - SPACE_C) : off_sum;
    end

    assign in_window = (offset < WINDOW_C);
    assign wr_idx    = offset[IDX_W-1:0];
    assign do_write  = cmd.accept && in_window && !full_reg[wr_idx];

    assign status.good_pkt      = pkt.checksum_ok;
    assign status.start_deliver = zero_reg && full_reg[0];
    assign status.more_deliver  = (WINDOW > 1) ? full_reg[WINDOW > 1 ? 1 : 0] : 1'b0;
    assign status.out_free      = !res_valid_reg || !res_stall;

    always_comb
    begin
        base_next      = base_reg;
        full_next      = full_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (do_write)
        begin
            full_next[wr_idx] = 1'b1;
        end
        if (cmd.emit_ack)
        begin
            res_next.result_kind       = KIND_ACK;
            res_next.ack_num           = seq_reg;
            res_next.delivered_payload = '0;
            res_next.last              = !(zero_reg && full_reg[0]);
            res_valid_next             = 1'b1;
        end
        else if (cmd.emit_deliver)
        begin
            res_next.result_kind       = KIND_DELIVER;
            res_next.ack_num           = '0;
            res_next.delivered_payload = PAYLOAD_FIELD_W'(payload_reg[0]);
            res_next.last              = !status.more_deliver;
            res_valid_next             = 1'b1;
            full_next                  = full_reg >> 1;
            base_next                  = (base_reg == BASE_MAX) ? '0 : base_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            full_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            full_reg      <= full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.accept)
        begin
            seq_reg  <= pkt.seq_num;
            zero_reg <= (offset == '0);
        end
        if (do_write)
        begin
            payload_reg[wr_idx] <= pkt.payload_word[PAYLOAD_BITS-1:0];
        end
        else if (cmd.emit_deliver)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                payload_reg[i] <= payload_reg[i + 1];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/srr_ctrl.sv =====
// Controller of the selective-repeat receiver: sequences acceptance, the
// acknowledgement and the in-order deliveries. Depends on srr_pkg.
module srr_ctrl
    import srr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_stall,
    input  srr_status_t status,
    output srr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_DELIVER
    } state_t;

    state_t state_reg, state_next;

    assign pkt_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd.accept       = 1'b0;
        cmd.emit_ack     = 1'b0;
        cmd.emit_deliver = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt_valid && status.good_pkt)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = status.start_deliver ? ST_DELIVER : ST_IDLE;
                end
            end
            ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    cmd.emit_deliver = 1'b1;
                    if (!status.more_deliver)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== dv/tb_selective_repeat_receiver_core.sv =====
// Testbench for selective_repeat_receiver_core: a directed table, then random
// packets, with every result checked against a typed acknowledgement or a predictor of the receive window.
// Depends on srr_pkg and the receiver core RTL.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_core
    import srr_pkg::*;
();

    localparam int WIN          = WINDOW_DEF;
    localparam int SEQ          = SEQ_SPACE_DEF;
    localparam int PREDICTED    = -1;
    localparam int RANDOM_ITEMS = 309;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        pkt_item_t              pkt;
        int                     n_typed;
        logic [SEQ_FIELD_W-1:0] exp_ack;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      pkt_valid = 1'b0;
    logic      pkt_stall;
    pkt_item_t pkt = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    int                         win_base = 0;
    bit                         buf_full [WIN];
    logic [PAYLOAD_FIELD_W-1:0] buf_data [WIN];
    res_item_t                  pending_results[$];
    dir_row_t                   directed[$];
    int                         fail_count = 0;
    int                         res_stall_left = 0;
    bit                         no_idle = 1'b0;

    selective_repeat_receiver_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #5 clk = ~clk;

    task automatic window_outcome(input pkt_item_t p, output res_item_t outs[$]);
        int        offset;
        int        run;
        res_item_t r;
        outs = {};
        if (p.checksum_ok)
        begin
            offset = (int'(p.seq_num) % SEQ + SEQ - win_base) % SEQ;
            r = '0;
            r.result_kind = KIND_ACK;
            r.ack_num = p.seq_num;
            outs.push_back(r);
            run = 0;
            if (offset < WIN)
            begin
                if (!buf_full[offset])
                begin
                    buf_full[offset] = 1'b1;
                    buf_data[offset] = p.payload_word;
                end
                if (offset == 0)
                begin
                    while (run < WIN && buf_full[run])
                    begin
                        r = '0;
                        r.result_kind = KIND_DELIVER;
                        r.delivered_payload = buf_data[run];
                        outs.push_back(r);
                        run++;
                    end
                    for (int i = 0; i < WIN; i++)
                    begin
                        if (i + run < WIN)
                        begin
                            buf_full[i] = buf_full[i + run];
                            buf_data[i] = buf_data[i + run];
                        end
                        else
                        begin
                            buf_full[i] = 1'b0;
                            buf_data[i] = '0;
                        end
                    end
                    win_base = (win_base + run) % SEQ;
                end
            end
            r = outs.pop_back();
            r.last = 1'b1;
            outs.push_back(r);
        end
    endtask

    task automatic add_row(input logic [SEQ_FIELD_W-1:0] seq,
                           input logic [PAYLOAD_FIELD_W-1:0] data, input logic ok,
                           input int n_typed, input logic [SEQ_FIELD_W-1:0] exp_ack);
        dir_row_t row;
        row.pkt.seq_num = seq;
        row.pkt.payload_word = data;
        row.pkt.checksum_ok = ok;
        row.n_typed = n_typed;
        row.exp_ack = exp_ack;
        directed.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic transfer_packet(input pkt_item_t p, input int n_typed,
                                   input logic [SEQ_FIELD_W-1:0] exp_ack);
        int        gap;
        res_item_t outcome[$];
        res_item_t r;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            pkt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_valid <= 1'b1;
        pkt <= p;
        @(posedge clk);
        while (pkt_stall) @(posedge clk);
        @(negedge clk);
        window_outcome(p, outcome);
        if (n_typed == PREDICTED)
        begin
            foreach (outcome[i]) pending_results.push_back(outcome[i]);
        end
        else if (n_typed == 1)
        begin
            r = '0;
            r.result_kind = KIND_ACK;
            r.ack_num = exp_ack;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result with no transaction pending: kind %0d ack %0d %s %h last %0d",
                       res.result_kind, res.ack_num, "payload",
                       res.delivered_payload, res.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.result_kind, res.result_kind);
                    fail_count++;
                end
                if (res.ack_num !== want.ack_num)
                begin
                    $error("ack_num: expected %0d, actual %0d", want.ack_num, res.ack_num);
                    fail_count++;
                end
                if (res.delivered_payload !== want.delivered_payload)
                begin
                    $error("delivered_payload: expected %h, actual %h",
                           want.delivered_payload, res.delivered_payload);
                    fail_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, res.last);
                    fail_count++;
                end
            end
            res_stall_left = no_idle ? 0 : $urandom_range(0, 10);
        end
    end

    always @(negedge clk)
    begin
        if (res_stall_left > 0)
        begin
            res_stall <= 1'b1;
            res_stall_left--;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    initial
    begin
        int        sent;
        int        pick;
        pkt_item_t p;

        add_row(3'd0, '1, 1'b0, 0, 3'd0);
        add_row(3'd4, '0, 1'b1, 1, 3'd4);
        add_row(3'd7, '1, 1'b1, 1, 3'd7);
        add_row(3'd1, '0, 1'b1, 1, 3'd1);
        add_row(3'd3, '1, 1'b1, 1, 3'd3);
        add_row(3'd3, 64'h5555_5555_5555_5555, 1'b1, 1, 3'd3);
        add_row(3'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, PREDICTED, 3'd0);
        add_row(3'd2, 64'h0123_4567_89AB_CDEF, 1'b1, PREDICTED, 3'd0);
        add_row(3'd7, 64'h8000_0000_0000_0001, 1'b1, 1, 3'd7);
        add_row(3'd6, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1, 3'd6);
        add_row(3'd5, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1, 3'd5);
        add_row(3'd5, 64'h1111_2222_3333_4444, 1'b1, 1, 3'd5);
        add_row(3'd4, '1, 1'b1, PREDICTED, 3'd0);
        add_row(3'd4, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1, 3'd4);
        add_row(3'd7, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1, 1, 3'd7);
        add_row(3'd0, '1, 1'b0, 0, 3'd0);
        add_row(3'd0, '0, 1'b1, PREDICTED, 3'd0);
        add_row(3'd0, 64'h3C3C_3C3C_3C3C_3C3C, 1'b1, 1, 3'd0);
        add_row(3'd1, '0, 1'b0, 0, 3'd0);
        add_row(3'd2, 64'hC3C3_C3C3_C3C3_C3C3, 1'b1, 1, 3'd2);
        add_row(3'd1, '1, 1'b1, PREDICTED, 3'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            transfer_packet(directed[i].pkt, directed[i].n_typed, directed[i].exp_ack);
        end

        // Most packets fall inside the window so that runs get delivered.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            p.checksum_ok = (pick >= 10);
            if (pick < 80)
            begin
                p.seq_num = SEQ_FIELD_W'((win_base + $urandom_range(0, WIN - 1)) % SEQ);
            end
            else
            begin
                p.seq_num = SEQ_FIELD_W'($urandom_range(0, SEQ - 1));
            end
            case ($urandom_range(0, 7))
                0:       p.payload_word = '1;
                1:       p.payload_word = '0;
                default: p.payload_word = {$urandom, $urandom};
            endcase
            transfer_packet(p, PREDICTED, '0);
            sent++;
        end
        pkt_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
